/* rtl/event_corner_arc_detector_defines.svh */
// ----------------------------------------------------------------------------
// Corner arc detector assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef EVENT_CORNER_ARC_DETECTOR_DEFINES_SVH
`define EVENT_CORNER_ARC_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define ECA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ECA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/eca_pkg.sv */
// ----------------------------------------------------------------------------
// Corner arc detector package
// Ring sizes, arc limits, request and state types shared by the detector, front end, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package eca_pkg;

    localparam int STAMP_BITS_DEF = 32;
    localparam int STAMP_IN_BITS  = 32;
    localparam int POS_BITS       = 6;

    localparam int INNER_N = 16;
    localparam int OUTER_N = 20;

    localparam int INNER_IDX_BITS = $clog2(INNER_N);
    localparam int OUTER_IDX_BITS = $clog2(OUTER_N);
    localparam int CNT_BITS       = $clog2(OUTER_N + 1);

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    localparam logic [POS_BITS-1:0] POS_INNER_END = POS_BITS'(INNER_N);
    localparam logic [POS_BITS-1:0] POS_OUTER_END = POS_BITS'(INNER_N + OUTER_N);

    localparam logic [OUTER_IDX_BITS-1:0] SCAN_INNER_END = OUTER_IDX_BITS'(INNER_N);
    localparam logic [OUTER_IDX_BITS-1:0] SCAN_LAST      = OUTER_IDX_BITS'(OUTER_N - 1);

    localparam logic [CNT_BITS-1:0] INNER_ARC_MIN = CNT_BITS'(3);
    localparam logic [CNT_BITS-1:0] INNER_ARC_MAX = CNT_BITS'(6);
    localparam logic [CNT_BITS-1:0] OUTER_ARC_MIN = CNT_BITS'(4);
    localparam logic [CNT_BITS-1:0] OUTER_ARC_MAX = CNT_BITS'(8);
    localparam logic [CNT_BITS-1:0] ONE_RISE      = CNT_BITS'(1);

    typedef enum logic [1:0] {
        RING_NONE,
        RING_INNER,
        RING_OUTER
    } ring_sel_t;

    typedef struct packed {
        ring_sel_t                 ring;
        logic [OUTER_IDX_BITS-1:0] index;
        logic                      last;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } back_state_t;

endpackage

`default_nettype wire

/* rtl/event_corner_arc_detector.sv */
// done rises once a popped last request has run its ring scan and a flush state.
// Throughput: one request per cycle into a 4-deep queue unless busy; the evaluator
//   retires one stamp per cycle, and a last request holds it for a 20-step ring scan.
// busy is high while the queue is full; results cannot be stalled by the receiver.
// Reset (rst_n low, asynchronous) empties the queue and idles the evaluator;
//   ring contents are left as they are.
// ----------------------------------------------------------------------------
// Event corner arc detector
// Collects inner and outer circle stamps and flags events whose rings hold
// a qualifying arc.
// ----------------------------------------------------------------------------
`default_nettype none

module event_corner_arc_detector #(
    parameter int STAMP_BITS = eca_pkg::STAMP_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [eca_pkg::STAMP_IN_BITS-1:0]  stamp,
    input  wire logic [eca_pkg::POS_BITS-1:0]       position,
    input  wire logic                               last,
    output logic                                    done,
    output logic                                    is_corner
);

    localparam int CMD_BITS  = $bits(eca_pkg::cmd_t);
    localparam int DATA_BITS = CMD_BITS + STAMP_BITS;

    logic                  push;
    logic                  pop;
    logic                  empty;
    eca_pkg::cmd_t         f_cmd;
    eca_pkg::cmd_t         q_cmd;
    logic [STAMP_BITS-1:0] f_stamp;
    logic [STAMP_BITS-1:0] q_stamp;
    logic [DATA_BITS-1:0]  q_wdata;
    logic [DATA_BITS-1:0]  q_rdata;

    eca_front #(
        .STAMP_BITS (STAMP_BITS)
    ) u_front (
        .start      (start),
        .full       (busy),
        .stamp      (stamp),
        .position   (position),
        .last       (last),
        .push       (push),
        .cmd        (f_cmd),
        .stamp_kept (f_stamp)
    );

    assign q_wdata = {f_cmd, f_stamp};
    assign q_cmd   = q_rdata[DATA_BITS-1 -: CMD_BITS];
    assign q_stamp = q_rdata[STAMP_BITS-1:0];

    eca_queue #(
        .DATA_BITS (DATA_BITS)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (q_wdata),
        .pop   (pop),
        .rdata (q_rdata),
        .full  (busy),
        .empty (empty)
    );

    eca_back #(
        .STAMP_BITS (STAMP_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .cmd       (q_cmd),
        .stamp     (q_stamp),
        .pop       (pop),
        .done      (done),
        .is_corner (is_corner)
    );

endmodule

`default_nettype wire

/* rtl/eca_front.sv */
// ----------------------------------------------------------------------------
// Corner arc detector front end
// Accepts requests and classifies each position into a ring and an index.
// ----------------------------------------------------------------------------
`default_nettype none

module eca_front #(
    parameter int STAMP_BITS = eca_pkg::STAMP_BITS_DEF
) (
    input  wire logic                               start,
    input  wire logic                               full,
    input  wire logic [eca_pkg::STAMP_IN_BITS-1:0]  stamp,
    input  wire logic [eca_pkg::POS_BITS-1:0]       position,
    input  wire logic                               last,
    output logic                                    push,
    output eca_pkg::cmd_t                           cmd,
    output logic [STAMP_BITS-1:0]                   stamp_kept
);

    localparam int IDX_BITS = eca_pkg::OUTER_IDX_BITS;

    logic [eca_pkg::POS_BITS-1:0] outer_off;

    assign push       = start && !full;
    assign stamp_kept = STAMP_BITS'(stamp);
    assign outer_off  = position - eca_pkg::POS_INNER_END;

    always_comb
    begin
        cmd.last  = last;
        cmd.index = '0;
        cmd.ring  = eca_pkg::RING_NONE;
        if (position < eca_pkg::POS_INNER_END)
        begin
            cmd.ring  = eca_pkg::RING_INNER;
            cmd.index = IDX_BITS'(position[eca_pkg::INNER_IDX_BITS-1:0]);
        end
        else if (position < eca_pkg::POS_OUTER_END)
        begin
            cmd.ring  = eca_pkg::RING_OUTER;
            cmd.index = outer_off[IDX_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

/* rtl/eca_queue.sv */
// ----------------------------------------------------------------------------
// Corner arc detector request queue
// Short FIFO that decouples the front end from the ring evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

module eca_queue #(
    parameter int DATA_BITS = 40
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire logic [DATA_BITS-1:0]  wdata,
    input  wire logic                  pop,
    output logic [DATA_BITS-1:0]       rdata,
    output logic                       full,
    output logic                       empty
);

    localparam int PTR_BITS = eca_pkg::QUEUE_PTR_BITS;
    localparam int CNT_BITS = PTR_BITS + 1;
    localparam logic [CNT_BITS-1:0] DEPTH = CNT_BITS'(eca_pkg::QUEUE_DEPTH);

    logic [DATA_BITS-1:0] mem_reg [eca_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;

    assign full  = (count_reg == DEPTH);
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/eca_back.sv */
// ----------------------------------------------------------------------------
// Corner arc detector back end
// Stores ring stamps and scans each ring for a qualifying arc.
// ----------------------------------------------------------------------------
`default_nettype none

module eca_back #(
    parameter int STAMP_BITS = eca_pkg::STAMP_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   empty,
    input  wire eca_pkg::cmd_t          cmd,
    input  wire logic [STAMP_BITS-1:0]  stamp,
    output logic                        pop,
    output logic                        done,
    output logic                        is_corner
);

    localparam int IN_N  = eca_pkg::INNER_N;
    localparam int OUT_N = eca_pkg::OUTER_N;
    localparam int CB    = eca_pkg::CNT_BITS;

    // A run qualifies when stamps >= its minimum form one arc-limited circular run.
    function automatic logic inner_arc(input logic [IN_N-1:0] m);
        logic [CB-1:0] cnt;
        logic [CB-1:0] rises;
        cnt   = '0;
        rises = '0;
        for (int i = 0; i < IN_N; i++)
        begin
            cnt   = cnt + CB'(m[i]);
            rises = rises + CB'(m[i] & ~m[(i + IN_N - 1) % IN_N]);
        end
        return (cnt >= eca_pkg::INNER_ARC_MIN) && (cnt <= eca_pkg::INNER_ARC_MAX) &&
               (rises == eca_pkg::ONE_RISE);
    endfunction

    function automatic logic outer_arc(input logic [OUT_N-1:0] m);
        logic [CB-1:0] cnt;
        logic [CB-1:0] rises;
        cnt   = '0;
        rises = '0;
        for (int i = 0; i < OUT_N; i++)
        begin
            cnt   = cnt + CB'(m[i]);
            rises = rises + CB'(m[i] & ~m[(i + OUT_N - 1) % OUT_N]);
        end
        return (cnt >= eca_pkg::OUTER_ARC_MIN) && (cnt <= eca_pkg::OUTER_ARC_MAX) &&
               (rises == eca_pkg::ONE_RISE);
    endfunction

    eca_pkg::back_state_t state_reg, state_next;

    logic [STAMP_BITS-1:0] inner_reg [IN_N];
    logic [STAMP_BITS-1:0] outer_reg [OUT_N];

    logic [eca_pkg::OUTER_IDX_BITS-1:0] k_reg, k_next;
    logic [IN_N-1:0]  inner_mask_reg, inner_mask_next;
    logic [OUT_N-1:0] outer_mask_reg, outer_mask_next;
    logic             inner_mv_reg, inner_mv_next;
    logic             outer_mv_reg, outer_mv_next;
    logic             inner_hit_reg, inner_hit_next;
    logic             outer_hit_reg, outer_hit_next;

    logic                  scan;
    logic                  scan_start;
    logic [STAMP_BITS-1:0] inner_pick;
    logic [STAMP_BITS-1:0] outer_pick;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            eca_pkg::ST_IDLE:
            begin
                if (!empty && cmd.last)
                begin
                    state_next = eca_pkg::ST_SCAN;
                end
            end
            eca_pkg::ST_SCAN:
            begin
                if (k_reg == eca_pkg::SCAN_LAST)
                begin
                    state_next = eca_pkg::ST_FLUSH;
                end
            end
            eca_pkg::ST_FLUSH:
            begin
                state_next = eca_pkg::ST_DONE;
            end
            eca_pkg::ST_DONE:
            begin
                state_next = eca_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = eca_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop  = 1'b0;
        scan = 1'b0;
        done = 1'b0;
        case (state_reg)
            eca_pkg::ST_IDLE:  pop  = !empty;
            eca_pkg::ST_SCAN:  scan = 1'b1;
            eca_pkg::ST_FLUSH: scan = 1'b0;
            eca_pkg::ST_DONE:  done = 1'b1;
            default:           pop  = 1'b0;
        endcase
    end

    assign scan_start = pop && cmd.last;
    assign is_corner  = inner_hit_reg && outer_hit_reg;

    assign inner_pick = inner_reg[k_reg[eca_pkg::INNER_IDX_BITS-1:0]];
    assign outer_pick = outer_reg[k_reg];

    always_comb
    begin
        for (int i = 0; i < IN_N; i++)
        begin
            inner_mask_next[i] = (inner_reg[i] >= inner_pick);
        end
        for (int i = 0; i < OUT_N; i++)
        begin
            outer_mask_next[i] = (outer_reg[i] >= outer_pick);
        end
        inner_mv_next = scan && (k_reg < eca_pkg::SCAN_INNER_END);
        outer_mv_next = scan;
        k_next        = (scan && (k_reg != eca_pkg::SCAN_LAST)) ? k_reg + 1'b1 : '0;

        inner_hit_next = inner_hit_reg || (inner_mv_reg && inner_arc(inner_mask_reg));
        outer_hit_next = outer_hit_reg || (outer_mv_reg && outer_arc(outer_mask_reg));
        if (scan_start)
        begin
            inner_hit_next = 1'b0;
            outer_hit_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && (cmd.ring == eca_pkg::RING_INNER))
        begin
            inner_reg[cmd.index[eca_pkg::INNER_IDX_BITS-1:0]] <= stamp;
        end
        if (pop && (cmd.ring == eca_pkg::RING_OUTER))
        begin
            outer_reg[cmd.index] <= stamp;
        end
        inner_mask_reg <= inner_mask_next;
        outer_mask_reg <= outer_mask_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= eca_pkg::ST_IDLE;
            k_reg         <= '0;
            inner_mv_reg  <= 1'b0;
            outer_mv_reg  <= 1'b0;
            inner_hit_reg <= 1'b0;
            outer_hit_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            inner_mv_reg  <= inner_mv_next;
            outer_mv_reg  <= outer_mv_next;
            inner_hit_reg <= inner_hit_next;
            outer_hit_reg <= outer_hit_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/eca_checker.sv */
// ----------------------------------------------------------------------------
// Corner arc detector port checker
// Watches the top-level handshake and result strobe over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "event_corner_arc_detector_defines.svh"

module eca_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);

    `ECA_ASSERT_NEXT(a_done_spacing, clk, rst_n, done, !done ##1 !done, "done strobes too close")
    `ECA_ASSERT_NOW(a_busy_after_push, clk, rst_n, $rose(busy), $past(start && !busy), "busy rose without a request")
    `ECA_ASSERT_NOW(a_reset_quiet, clk, rst_n, $rose(rst_n), !busy && !done, "not idle after reset")

endmodule

bind event_corner_arc_detector eca_checker u_eca_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

`default_nettype wire
